@@ design/fspd_pkg.sv @@
package fspd_pkg;

   localparam int TURN_BITS    = 54;
   localparam int CORDIC_STEPS = 54;
   localparam int XY_W         = 64;
   localparam int Z_W          = TURN_BITS + 2;
   localparam int PIX_W        = TURN_BITS + 9;
   localparam int WORD_W       = 8;
   localparam int POS_W        = 16;
   localparam int PIPE_LATENCY = CORDIC_STEPS + 7;

   localparam logic [TURN_BITS:0] QUARTER_TURN = (TURN_BITS+1)'(1) << (TURN_BITS - 2);
   localparam logic [TURN_BITS:0] EIGHTH_TURN  = (TURN_BITS+1)'(1) << (TURN_BITS - 3);
   localparam logic [TURN_BITS:0] HALF_TURN    = (TURN_BITS+1)'(1) << (TURN_BITS - 1);
   localparam logic [TURN_BITS:0] FULL_TURN    = (TURN_BITS+1)'(1) << TURN_BITS;

   typedef enum logic [2:0] {
      ANG_FLAT,
      ANG_ON_COS,
      ANG_ON_SIN,
      ANG_DIAG,
      ANG_LOW,
      ANG_HIGH
   } ang_kind_type;

   typedef struct packed {
      ang_kind_type kind;
      logic         sin_neg;
      logic         cos_neg;
   } pix_tag_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } cordic_vec_type;

   typedef logic [TURN_BITS-1:0] arc_entry_type;
   typedef arc_entry_type [CORDIC_STEPS-1:0] arc_tab_type;

   // atan(2^-i) in turns scaled by 2^TURN_BITS, from series in 2^62 fixed point
   function automatic arc_tab_type build_arc_tab();
      logic [63:0] quarter;
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] t;
      logic [63:0] rem;
      logic [63:0] q;
      logic [63:0] a5;
      logic [63:0] a239;
      logic        neg;
      int          k;
      int          i;
      int          j;
      int          e;
      int          m;
      int          r;
      arc_tab_type tab;
      a5   = '0;
      a239 = '0;
      for (r = 0; r < 2; r++) begin
         m   = (r == 0) ? 5 : 239;
         p   = (64'd1 << 62) / 64'(m);
         sum = '0;
         neg = 1'b0;
         k   = 0;
         while (p != 64'd0) begin
            t   = p / 64'(2 * k + 1);
            sum = neg ? sum - t : sum + t;
            neg = !neg;
            p   = p / 64'(m * m);
            k++;
         end
         if (r == 0) begin
            a5 = sum;
         end else begin
            a239 = sum;
         end
      end
      quarter = 64'd4 * a5 - a239;
      tab[0]  = arc_entry_type'(64'd1 << (TURN_BITS - 3));
      for (i = 1; i < CORDIC_STEPS; i++) begin
         sum = '0;
         neg = 1'b0;
         k   = 0;
         e   = i;
         while (e <= 62) begin
            t   = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            sum = neg ? sum - t : sum + t;
            neg = !neg;
            k++;
            e   = i * (2 * k + 1);
         end
         rem = sum;
         q   = '0;
         for (j = 0; j < TURN_BITS - 3; j++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= quarter) begin
               rem  = rem - quarter;
               q[0] = 1'b1;
            end
         end
         tab[i] = q[TURN_BITS-1:0];
      end
      return tab;
   endfunction

   localparam arc_tab_type ARC_TAB = build_arc_tab();

   // shift right rounding toward zero
   function automatic logic signed [XY_W-1:0] shr_tz(input logic signed [XY_W-1:0] v,
                                                     input int s);
      logic [XY_W-1:0] mask;
      logic            fix;
      mask = (XY_W'(1) << s) - XY_W'(1);
      fix  = v[XY_W-1] && ((v & mask) != '0);
      return (v >>> s) + $signed(XY_W'(fix));
   endfunction

endpackage

@@ design/fspd_cordic_stage.sv @@
module fspd_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     valid_i,
   input  fspd_pkg::cordic_vec_type vec_i,
   input  fspd_pkg::pix_tag_type    tag_i,
   output logic                     valid_o,
   output fspd_pkg::cordic_vec_type vec_o,
   output fspd_pkg::pix_tag_type    tag_o
);

   logic                     valid_ff;
   fspd_pkg::cordic_vec_type vec_ff;
   fspd_pkg::cordic_vec_type vec_in;
   fspd_pkg::pix_tag_type    tag_ff;
   logic signed [fspd_pkg::XY_W-1:0] dx;
   logic signed [fspd_pkg::XY_W-1:0] dy;
   logic signed [fspd_pkg::Z_W-1:0]  da;

   always_comb begin
      dx = fspd_pkg::shr_tz(vec_i.y, STEP);
      dy = fspd_pkg::shr_tz(vec_i.x, STEP);
      da = $signed(fspd_pkg::Z_W'(fspd_pkg::ARC_TAB[STEP]));
      if (!vec_i.y[fspd_pkg::XY_W-1]) begin
         vec_in.x = vec_i.x + dx;
         vec_in.y = vec_i.y - dy;
         vec_in.z = vec_i.z + da;
      end else begin
         vec_in.x = vec_i.x - dx;
         vec_in.y = vec_i.y + dy;
         vec_in.z = vec_i.z - da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
      vec_ff <= vec_in;
      tag_ff <= tag_i;
   end

   assign valid_o = valid_ff;
   assign vec_o   = vec_ff;
   assign tag_o   = tag_ff;

endmodule

@@ design/four_step_phase_decoder.sv @@
// channel   ports                                       direction  handshake
// request   start busy req_grey_shift_0/90/180/270      in         start && !busy
// response  rsp_strobe rsp_stripe_position               out        rsp_strobe, one cycle
// config    csr_write_enable csr_write_data              in         csr_write_enable
//
// one word accepted per cycle, each result registered in turn by the capture, class,
// cordic, angle, fold, scale, wrap and round stages; the cordic chain has 54 steps, one per register stage
// busy is high only during reset; the pipeline never stalls
// synchronous reset clears all valid bits and sets period_ff to 16
module four_step_phase_decoder #(
   parameter int FRAC_BITS = 8,
   parameter int GREY_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fspd_pkg::WORD_W-1:0]   req_grey_shift_0,
   input  logic [fspd_pkg::WORD_W-1:0]   req_grey_shift_90,
   input  logic [fspd_pkg::WORD_W-1:0]   req_grey_shift_180,
   input  logic [fspd_pkg::WORD_W-1:0]   req_grey_shift_270,
   output logic                          rsp_strobe,
   output logic [fspd_pkg::POS_W-1:0]    rsp_stripe_position,
   input  logic                          csr_write_enable,
   input  logic [fspd_pkg::WORD_W-1:0]   csr_write_data
);

   localparam int GW        = GREY_BITS;
   localparam int VEC_SHIFT = 60 - GREY_BITS;
   localparam int TB        = fspd_pkg::TURN_BITS;
   localparam int SH        = TB - FRAC_BITS;
   localparam int SUM_W     = fspd_pkg::PIX_W + 3;
   localparam int NS        = fspd_pkg::CORDIC_STEPS;

   logic [fspd_pkg::WORD_W-1:0] period_ff;

   logic          in_valid_ff;
   logic [GW-1:0] in_g0_ff;
   logic [GW-1:0] in_g1_ff;
   logic [GW-1:0] in_g2_ff;
   logic [GW-1:0] in_g3_ff;

   logic signed [GW:0] ds;
   logic signed [GW:0] dc;
   logic signed [GW:0] ds_abs;
   logic signed [GW:0] dc_abs;
   logic [GW-1:0]      as;
   logic [GW-1:0]      ac;
   fspd_pkg::pix_tag_type cls_tag_in;

   logic                  cls_valid_ff;
   fspd_pkg::pix_tag_type cls_tag_ff;
   logic [GW-1:0]         cls_num_ff;
   logic [GW-1:0]         cls_den_ff;
   logic [GW-1:0]         cls_num_in;
   logic [GW-1:0]         cls_den_in;

   logic                     valid_chain [0:NS];
   fspd_pkg::cordic_vec_type vec_chain   [0:NS];
   fspd_pkg::pix_tag_type    tag_chain   [0:NS];

   logic [TB-1:0]         zc;
   logic [TB-1:0]         alpha_in;
   logic                  alpha_valid_ff;
   logic [TB-1:0]         alpha_ff;
   fspd_pkg::pix_tag_type alpha_tag_ff;

   logic [TB:0]   theta_wide;
   logic          theta_valid_ff;
   logic [TB-1:0] theta_ff;

   logic                         pix_valid_ff;
   logic [fspd_pkg::PIX_W-1:0]   pix_ff;
   logic                         wrap_valid_ff;
   logic [fspd_pkg::PIX_W-1:0]   wrap_ff;
   logic [fspd_pkg::PIX_W-1:0]   wrap_in;
   logic [fspd_pkg::PIX_W-1:0]   period_fx;
   logic [SUM_W-1:0]             round_sum;

   logic                       rsp_valid_ff;
   logic [fspd_pkg::POS_W-1:0] rsp_pos_ff;

   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= fspd_pkg::WORD_W'(16);
      end else if (csr_write_enable) begin
         period_ff <= csr_write_data;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      in_g0_ff <= GW'(req_grey_shift_0);
      in_g1_ff <= GW'(req_grey_shift_90);
      in_g2_ff <= GW'(req_grey_shift_180);
      in_g3_ff <= GW'(req_grey_shift_270);
   end

   // differences, magnitudes and octant class
   always_comb begin
      ds     = $signed({1'b0, in_g0_ff}) - $signed({1'b0, in_g2_ff});
      dc     = $signed({1'b0, in_g1_ff}) - $signed({1'b0, in_g3_ff});
      ds_abs = ds[GW] ? -ds : ds;
      dc_abs = dc[GW] ? -dc : dc;
      as     = ds_abs[GW-1:0];
      ac     = dc_abs[GW-1:0];
      cls_tag_in.sin_neg = ds[GW];
      cls_tag_in.cos_neg = dc[GW];
      priority if (as == '0 && ac == '0) begin
         cls_tag_in.kind = fspd_pkg::ANG_FLAT;
      end else if (as == '0) begin
         cls_tag_in.kind = fspd_pkg::ANG_ON_COS;
      end else if (ac == '0) begin
         cls_tag_in.kind = fspd_pkg::ANG_ON_SIN;
      end else if (as == ac) begin
         cls_tag_in.kind = fspd_pkg::ANG_DIAG;
      end else if (as < ac) begin
         cls_tag_in.kind = fspd_pkg::ANG_LOW;
      end else begin
         cls_tag_in.kind = fspd_pkg::ANG_HIGH;
      end
      cls_num_in = (as < ac) ? as : ac;
      cls_den_in = (as < ac) ? ac : as;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
      end else begin
         cls_valid_ff <= in_valid_ff;
      end
      cls_tag_ff <= cls_tag_in;
      cls_num_ff <= cls_num_in;
      cls_den_ff <= cls_den_in;
   end

   // cordic vectoring chain
   assign valid_chain[0] = cls_valid_ff;
   assign tag_chain[0]   = cls_tag_ff;
   assign vec_chain[0].x = $signed(fspd_pkg::XY_W'(cls_den_ff) << VEC_SHIFT);
   assign vec_chain[0].y = $signed(fspd_pkg::XY_W'(cls_num_ff) << VEC_SHIFT);
   assign vec_chain[0].z = '0;

   for (genvar s = 0; s < NS; s++) begin : g_step
      fspd_cordic_stage #(
         .STEP(s)
      ) u_step (
         .clock   (clock),
         .reset   (reset),
         .valid_i (valid_chain[s]),
         .vec_i   (vec_chain[s]),
         .tag_i   (tag_chain[s]),
         .valid_o (valid_chain[s+1]),
         .vec_o   (vec_chain[s+1]),
         .tag_o   (tag_chain[s+1])
      );
   end

   // first-quadrant angle
   always_comb begin
      zc = vec_chain[NS].z[fspd_pkg::Z_W-1] ? '0 : vec_chain[NS].z[TB-1:0];
      unique case (tag_chain[NS].kind)
         fspd_pkg::ANG_FLAT:   alpha_in = '0;
         fspd_pkg::ANG_ON_COS: alpha_in = '0;
         fspd_pkg::ANG_ON_SIN: alpha_in = fspd_pkg::QUARTER_TURN[TB-1:0];
         fspd_pkg::ANG_DIAG:   alpha_in = fspd_pkg::EIGHTH_TURN[TB-1:0];
         fspd_pkg::ANG_LOW:    alpha_in = zc;
         fspd_pkg::ANG_HIGH:   alpha_in = fspd_pkg::QUARTER_TURN[TB-1:0] - zc;
         default:              alpha_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_valid_ff <= 1'b0;
      end else begin
         alpha_valid_ff <= valid_chain[NS];
      end
      alpha_ff     <= alpha_in;
      alpha_tag_ff <= tag_chain[NS];
   end

   // quadrant fold to a full turn
   always_comb begin
      priority if (alpha_tag_ff.kind == fspd_pkg::ANG_FLAT) begin
         theta_wide = '0;
      end else if (!alpha_tag_ff.cos_neg && !alpha_tag_ff.sin_neg) begin
         theta_wide = {1'b0, alpha_ff};
      end else if (alpha_tag_ff.cos_neg && !alpha_tag_ff.sin_neg) begin
         theta_wide = fspd_pkg::HALF_TURN - {1'b0, alpha_ff};
      end else if (alpha_tag_ff.cos_neg) begin
         theta_wide = fspd_pkg::HALF_TURN + {1'b0, alpha_ff};
      end else begin
         theta_wide = fspd_pkg::FULL_TURN - {1'b0, alpha_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         theta_valid_ff <= 1'b0;
      end else begin
         theta_valid_ff <= alpha_valid_ff;
      end
      theta_ff <= theta_wide[TB-1:0];
   end

   // scale by period plus half a pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= theta_valid_ff;
      end
      pix_ff <= fspd_pkg::PIX_W'(theta_ff) * fspd_pkg::PIX_W'(period_ff)
              + fspd_pkg::PIX_W'(fspd_pkg::HALF_TURN);
   end

   // wrap by one period
   always_comb begin
      period_fx = fspd_pkg::PIX_W'(period_ff) << TB;
      wrap_in   = (pix_ff > period_fx) ? pix_ff - period_fx : pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
      end else begin
         wrap_valid_ff <= pix_valid_ff;
      end
      wrap_ff <= wrap_in;
   end

   // round half up to the output fraction
   assign round_sum = SUM_W'(wrap_ff) + (SUM_W'(1) << (SH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= wrap_valid_ff;
      end
      rsp_pos_ff <= round_sum[SH +: fspd_pkg::POS_W];
   end

   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_stripe_position = rsp_pos_ff;

endmodule

@@ design/fspd_checker.sv @@
module fspd_checker #(
   parameter int FRAC_BITS = 8
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [fspd_pkg::WORD_W-1:0] req_grey_shift_0,
   input logic [fspd_pkg::WORD_W-1:0] req_grey_shift_90,
   input logic [fspd_pkg::WORD_W-1:0] req_grey_shift_180,
   input logic [fspd_pkg::WORD_W-1:0] req_grey_shift_270,
   input logic                        rsp_strobe,
   input logic [fspd_pkg::POS_W-1:0]  rsp_stripe_position
);

   localparam int LAT = fspd_pkg::PIPE_LATENCY;

   logic accept;
   logic flat_word;
   logic [fspd_pkg::POS_W-1:0] half_pixel;

   assign accept     = start && !busy;
   assign flat_word  = (req_grey_shift_0 == req_grey_shift_180)
                    && (req_grey_shift_90 == req_grey_shift_270);
   assign half_pixel = fspd_pkg::POS_W'(1) << (FRAC_BITS - 1);

   // reset empties the pipeline
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // every result comes from an earlier accepted word
   a_strobe_source : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LAT))
      else $error("result without matching request");

   // flat pixel decodes to half a pixel
   a_flat_pixel : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(accept && flat_word, LAT)) |-> rsp_stripe_position == half_pixel)
      else $error("flat pixel did not decode to half a pixel");

endmodule

bind four_step_phase_decoder fspd_checker #(
   .FRAC_BITS(FRAC_BITS)
) u_fspd_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_grey_shift_0    (req_grey_shift_0),
   .req_grey_shift_90   (req_grey_shift_90),
   .req_grey_shift_180  (req_grey_shift_180),
   .req_grey_shift_270  (req_grey_shift_270),
   .rsp_strobe          (rsp_strobe),
   .rsp_stripe_position (rsp_stripe_position)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int TURNS          = 54;
   localparam int STEPS          = 54;
   localparam int VEC_SHIFT      = 52;
   localparam int FRAC           = 8;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 163;
   localparam int DIRECTED_COUNT = 21;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [63:0] QTR_TURN  = 64'd1 << (TURNS - 2);
   localparam logic [63:0] HALF_TURN = 64'd1 << (TURNS - 1);
   localparam logic [63:0] FULL_TURN = 64'd1 << TURNS;

   typedef struct packed {
      logic [7:0] g0;
      logic [7:0] g90;
      logic [7:0] g180;
      logic [7:0] g270;
   } pixel_word_type;

   typedef enum int {
      MIX_FLAT,
      MIX_SIN_ZERO,
      MIX_COS_ZERO,
      MIX_DIAG,
      MIX_RAIL,
      MIX_NEAR,
      MIX_UNIFORM
   } stim_mix_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_grey_shift_0 = '0;
   logic [7:0]  req_grey_shift_90 = '0;
   logic [7:0]  req_grey_shift_180 = '0;
   logic [7:0]  req_grey_shift_270 = '0;
   logic        rsp_strobe;
   logic [15:0] rsp_stripe_position;
   logic        csr_write_enable = 1'b0;
   logic [7:0]  csr_write_data = '0;

   pixel_word_type pending_pixels[$];
   logic [15:0] expected_positions[$];
   longint      atan_turns[STEPS];
   logic [7:0]  period_now = 8'd16;
   int          sender_idle_pct = 0;
   int          fail_count = 0;
   int          stall_cycles = 0;

   four_step_phase_decoder DUT (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_grey_shift_0    (req_grey_shift_0),
      .req_grey_shift_90   (req_grey_shift_90),
      .req_grey_shift_180  (req_grey_shift_180),
      .req_grey_shift_270  (req_grey_shift_270),
      .rsp_strobe          (rsp_strobe),
      .rsp_stripe_position (rsp_stripe_position),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #10 clock = ~clock;

   // atan(1/m) scaled by 2^62
   function automatic logic [63:0] atan_inv(input logic [63:0] m);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] t;
      int          k;
      logic        neg;
      p   = (64'd1 << 62) / m;
      sum = '0;
      k   = 0;
      neg = 1'b0;
      while (p != 64'd0) begin
         t   = p / 64'(2 * k + 1);
         sum = neg ? sum - t : sum + t;
         neg = !neg;
         p   = p / (m * m);
         k++;
      end
      return sum;
   endfunction

   // vectoring cordic, atan(num/den) in turns at 2^-54
   function automatic longint cordic_turns(input int num, input int den);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = longint'(den) <<< VEC_SHIFT;
      y = longint'(num) <<< VEC_SHIFT;
      z = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = (y >= 0) ? (y >>> i) : -((-y) >>> i);
         dy = (x >= 0) ? (x >>> i) : -((-x) >>> i);
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + atan_turns[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - atan_turns[i];
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic logic [15:0] decode_position(input pixel_word_type px,
                                                   input logic [7:0] period);
      int          sin_diff;
      int          cos_diff;
      int          sin_mag;
      int          cos_mag;
      logic [63:0] alpha;
      logic [63:0] theta;
      logic [63:0] pos;
      logic [63:0] span;
      sin_diff = int'(px.g0) - int'(px.g180);
      cos_diff = int'(px.g90) - int'(px.g270);
      sin_mag  = (sin_diff < 0) ? -sin_diff : sin_diff;
      cos_mag  = (cos_diff < 0) ? -cos_diff : cos_diff;
      if (sin_mag == 0 && cos_mag == 0) begin
         theta = '0;
      end else begin
         if (sin_mag == 0) begin
            alpha = '0;
         end else if (cos_mag == 0) begin
            alpha = QTR_TURN;
         end else if (sin_mag == cos_mag) begin
            alpha = QTR_TURN >> 1;
         end else if (sin_mag < cos_mag) begin
            alpha = 64'(cordic_turns(sin_mag, cos_mag));
         end else begin
            alpha = QTR_TURN - 64'(cordic_turns(cos_mag, sin_mag));
         end
         if (cos_diff >= 0 && sin_diff >= 0) begin
            theta = alpha;
         end else if (cos_diff < 0 && sin_diff >= 0) begin
            theta = HALF_TURN - alpha;
         end else if (cos_diff < 0) begin
            theta = HALF_TURN + alpha;
         end else begin
            theta = FULL_TURN - alpha;
         end
         if (theta >= FULL_TURN) begin
            theta = theta - FULL_TURN;
         end
      end
      pos  = theta * 64'(period) + HALF_TURN;
      span = 64'(period) << TURNS;
      // wrap decided before rounding
      if (pos > span) begin
         pos = pos - span;
      end
      pos = (pos + (64'd1 << (TURNS - FRAC - 1))) >> (TURNS - FRAC);
      return pos[15:0];
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (pending_pixels.size() != 0 || start || expected_positions.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // driver
   always @(posedge clock) begin : driver
      pixel_word_type nxt;
      pixel_word_type cur;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            cur = '{req_grey_shift_0, req_grey_shift_90, req_grey_shift_180,
                    req_grey_shift_270};
            expected_positions.push_back(decode_position(cur, period_now));
         end
         if (!(start && busy)) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               nxt = pending_pixels.pop_front();
               req_grey_shift_0   <= nxt.g0;
               req_grey_shift_90  <= nxt.g90;
               req_grey_shift_180 <= nxt.g180;
               req_grey_shift_270 <= nxt.g270;
               start              <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      logic [15:0] want;
      if (!reset && rsp_strobe) begin
         if (expected_positions.size() == 0) begin
            $error("stripe_position: no word expected, actual %0d", rsp_stripe_position);
            fail_count++;
         end else begin
            want = expected_positions.pop_front();
            if (rsp_stripe_position !== want) begin
               $error("stripe_position: expected %0d, actual %0d", want,
                      rsp_stripe_position);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [63:0] quarter;
      logic [63:0] sum;
      logic [63:0] t;
      logic [63:0] rem;
      logic [63:0] q;
      logic        neg;
      int          k;
      int          e;
      int          ph;
      int          n;
      int          pick;
      int          mag;
      int          lo;
      int          period_val;
      stim_mix_type   mix;
      pixel_word_type w;
      logic [31:0] directed_words[DIRECTED_COUNT];
      int          period_plan[PHASES];
      int          idle_plan[PHASES];

      // arctangent table in turns
      quarter       = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
      atan_turns[0] = longint'(64'd1 << (TURNS - 3));
      for (int i = 1; i < STEPS; i++) begin
         sum = '0;
         neg = 1'b0;
         k   = 0;
         e   = i;
         while (e <= 62) begin
            t   = (64'd1 << (62 - e)) / 64'(2 * k + 1);
            sum = neg ? sum - t : sum + t;
            neg = !neg;
            k++;
            e   = i * (2 * k + 1);
         end
         rem = sum;
         q   = '0;
         for (int j = 0; j < TURNS - 3; j++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= quarter) begin
               rem  = rem - quarter;
               q[0] = 1'b1;
            end
         end
         atan_turns[i] = longint'(q);
      end

      directed_words = '{
         32'h00000000, 32'hFFFFFFFF, 32'h80808080, 32'hFF000000, 32'h00FF0000,
         32'h0000FF00, 32'h000000FF, 32'hFFFF0000, 32'h00FFFF00, 32'h0000FFFF,
         32'hFF0000FF, 32'h01FF0000, 32'hFF010000, 32'h00FF0100, 32'h0000FF01,
         32'h01000000, 32'h80807F7F, 32'hAA55AA55, 32'h55AAAA55, 32'hAA5555AA,
         32'h7F80807F
      };
      period_plan = '{255, 1, 0, 16, 100, 37, 200, -1};
      idle_plan   = '{0, 51, 7, 0, 51, 7, 51, 0};

      // directed words at the reset period
      for (n = 0; n < DIRECTED_COUNT; n++) begin
         pending_pixels.push_back(pixel_word_type'(directed_words[n]));
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         period_val = (period_plan[ph] < 0) ? $urandom_range(1, 255) : period_plan[ph];
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_write_data   <= 8'(period_val);
         @(posedge clock);
         csr_write_enable <= 1'b0;
         period_now       = 8'(period_val);
         sender_idle_pct  = idle_plan[ph];
         for (n = 0; n < PHASE_ITEMS; n++) begin
            w.g0   = 8'($urandom);
            w.g90  = 8'($urandom);
            w.g180 = 8'($urandom);
            w.g270 = 8'($urandom);
            pick   = $urandom_range(0, 9);
            mix    = (pick > MIX_UNIFORM) ? MIX_UNIFORM : stim_mix_type'(pick);
            case (mix)
               MIX_FLAT: begin
                  w.g180 = w.g0;
                  w.g270 = w.g90;
               end
               MIX_SIN_ZERO: begin
                  w.g180 = w.g0;
               end
               MIX_COS_ZERO: begin
                  w.g270 = w.g90;
               end
               MIX_DIAG: begin
                  mag = (w.g0 > w.g180) ? w.g0 - w.g180 : w.g180 - w.g0;
                  lo  = $urandom_range(0, 255 - mag);
                  if ($urandom_range(0, 1)) begin
                     w.g90  = 8'(lo + mag);
                     w.g270 = 8'(lo);
                  end else begin
                     w.g90  = 8'(lo);
                     w.g270 = 8'(lo + mag);
                  end
               end
               MIX_RAIL: begin
                  w.g0   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  w.g90  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  w.g180 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  w.g270 = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               end
               MIX_NEAR: begin
                  w.g180 = w.g0 ^ 8'($urandom_range(0, 3));
                  w.g270 = w.g90 ^ 8'($urandom_range(0, 3));
               end
               default: begin
               end
            endcase
            pending_pixels.push_back(w);
         end
      end

      wait_drained();
      repeat (fspd_pkg::PIPE_LATENCY + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ four_step_phase_decoder.f @@
design/fspd_pkg.sv
design/fspd_cordic_stage.sv
design/four_step_phase_decoder.sv
design/fspd_checker.sv
dv/tb_top.sv
